### hdl/compass_heading_from_field_unit_assert.svh
// ============================================================================
// Compass heading unit assertion macros
// Concurrent assertion shorthands for the compass heading unit.
// ============================================================================
`ifndef COMPASS_HEADING_FROM_FIELD_UNIT_ASSERT_SVH
`define COMPASS_HEADING_FROM_FIELD_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CHF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("compass heading unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CHF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("compass heading unit: next-cycle check failed");

`endif

### hdl/chf_pkg.sv
// ============================================================================
// Compass heading package
// Shared constants, control type and the CORDIC arctangent table.
// ============================================================================
`timescale 1ns / 1ps

package chf_pkg;

   localparam int CHF_SAMPLE_WIDTH  = 16;
   localparam int CHF_CORDIC_STAGES = 16;

   // Samples are scaled by 2^8 before the first rotation.
   localparam int GUARD_BITS = 8;

   // Angle accumulator in units of 2^-16 degree.
   localparam int ANGLE_WIDTH = 27;
   localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_90  = ANGLE_WIDTH'(90 * 65536);
   localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_180 = ANGLE_WIDTH'(180 * 65536);

   // Rounding to 2^-7 degree: add half an LSB, then shift.
   localparam int ROUND_SHIFT = 9;
   localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

   // Fine heading in units of 1/7680 degree.
   localparam int FINE_WIDTH  = 25;
   localparam int FULL_CIRCLE = 360 * 7680;

   // A reduced fine heading fits in 22 bits; 7680 = 15 * 2^9.
   localparam int MOD_WIDTH   = 22;
   localparam int DEG_SHIFT   = 9;
   localparam int QUOT_WIDTH  = MOD_WIDTH - DEG_SHIFT;

   // Division by 15 as a reciprocal multiply, exact for inputs below 10082.
   localparam int DIV15_MULT  = 8739;
   localparam int DIV15_SHIFT = 17;
   localparam int PROD_WIDTH  = 27;

   localparam int HEADING_WIDTH = 9;
   localparam int DECL_WIDTH    = 15;

   typedef struct packed {
      logic valid;
      logic hold;
   } chf_ctrl_type;

   // round(atan(2^-i) * 180 / pi * 2^16)
   function automatic logic signed [ANGLE_WIDTH-1:0] chf_atan(input int idx);
      logic signed [ANGLE_WIDTH-1:0] val;
      case (idx)
         0:       val = ANGLE_WIDTH'(2949120);
         1:       val = ANGLE_WIDTH'(1740967);
         2:       val = ANGLE_WIDTH'(919879);
         3:       val = ANGLE_WIDTH'(466945);
         4:       val = ANGLE_WIDTH'(234379);
         5:       val = ANGLE_WIDTH'(117304);
         6:       val = ANGLE_WIDTH'(58666);
         7:       val = ANGLE_WIDTH'(29335);
         8:       val = ANGLE_WIDTH'(14668);
         9:       val = ANGLE_WIDTH'(7334);
         10:      val = ANGLE_WIDTH'(3667);
         11:      val = ANGLE_WIDTH'(1833);
         12:      val = ANGLE_WIDTH'(917);
         13:      val = ANGLE_WIDTH'(458);
         14:      val = ANGLE_WIDTH'(229);
         15:      val = ANGLE_WIDTH'(115);
         16:      val = ANGLE_WIDTH'(57);
         17:      val = ANGLE_WIDTH'(29);
         18:      val = ANGLE_WIDTH'(14);
         19:      val = ANGLE_WIDTH'(7);
         20:      val = ANGLE_WIDTH'(4);
         21:      val = ANGLE_WIDTH'(2);
         22:      val = ANGLE_WIDTH'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### hdl/chf_cordic_stage.sv
// ============================================================================
// CORDIC vectoring stage
// One registered micro-rotation toward y = 0 with its angle update.
// ============================================================================
`timescale 1ns / 1ps

module chf_cordic_stage
   import chf_pkg::*;
#(
   parameter int DATA_WIDTH = CHF_SAMPLE_WIDTH + GUARD_BITS + 3,
   parameter int SHIFT      = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  chf_ctrl_type                  up_ctrl,
   input  logic signed [DATA_WIDTH-1:0]  up_x,
   input  logic signed [DATA_WIDTH-1:0]  up_y,
   input  logic signed [ANGLE_WIDTH-1:0] up_z,
   output chf_ctrl_type                  dn_ctrl,
   output logic signed [DATA_WIDTH-1:0]  dn_x,
   output logic signed [DATA_WIDTH-1:0]  dn_y,
   output logic signed [ANGLE_WIDTH-1:0] dn_z
);

   localparam logic signed [ANGLE_WIDTH-1:0] STEP_ANGLE = chf_atan(SHIFT);

   chf_ctrl_type                  ctrl_ff;
   logic signed [DATA_WIDTH-1:0]  x_ff, x_in;
   logic signed [DATA_WIDTH-1:0]  y_ff, y_in;
   logic signed [ANGLE_WIDTH-1:0] z_ff, z_in;
   logic signed [DATA_WIDTH-1:0]  dx, dy;

   // Axis cases arrive with an exact angle and pass through untouched.
   always_comb begin
      dx = up_y >>> SHIFT;
      dy = up_x >>> SHIFT;
      if (up_ctrl.hold) begin
         x_in = up_x;
         y_in = up_y;
         z_in = up_z;
      end else if (!up_y[DATA_WIDTH-1]) begin
         x_in = up_x + dx;
         y_in = up_y - dy;
         z_in = up_z + STEP_ANGLE;
      end else begin
         x_in = up_x - dx;
         y_in = up_y + dy;
         z_in = up_z - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (load) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_x    = x_ff;
   assign dn_y    = y_ff;
   assign dn_z    = z_ff;

endmodule

### hdl/compass_heading_from_field_unit.sv
// ============================================================================
// Compass heading from field unit
// Pipelined CORDIC atan2 with declination, wrap and whole-degree output.
// ============================================================================
// A word carrying one magnetometer sample pair enters at req_ and leaves
// as a heading in whole degrees, 0 to 359, on rsp_. The unit takes one
// word every cycle unless rsp_stall holds it back; that rate is set by the
// chain of register stages, one per CORDIC micro-rotation plus an entry
// stage and four post-processing stages. Each stage holds its own valid
// bit and moves forward when the stage after it is empty or moving, so
// bubbles close up and req_stall rises only when every stage is full and
// rsp_stall is high. The declination register is written through
// csr_write_enable and csr_declination_arcmin (signed arcminutes) and must
// only change while no word is in flight.
`timescale 1ns / 1ps

`include "compass_heading_from_field_unit_assert.svh"

module compass_heading_from_field_unit
   import chf_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = CHF_SAMPLE_WIDTH,
   parameter int CORDIC_STAGES = CHF_CORDIC_STAGES
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_mag_x,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_mag_y,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic        [HEADING_WIDTH-1:0] rsp_heading_degrees,

   input  logic                            csr_write_enable,
   input  logic signed [DECL_WIDTH-1:0]    csr_declination_arcmin
);

   // Sign bit, one bit for negating the most negative sample, the guard
   // bits and two bits for CORDIC gain.
   localparam int DW   = SAMPLE_WIDTH + 1 + GUARD_BITS + 2;
   localparam int N    = CORDIC_STAGES;
   localparam int LAST = N + 4;
   localparam int QW   = ANGLE_WIDTH - ROUND_SHIFT + 1;

   localparam logic signed [FINE_WIDTH-1:0] FULL_FINE  = FINE_WIDTH'(FULL_CIRCLE);
   localparam logic signed [FINE_WIDTH-1:0] FULL_FINE2 = FINE_WIDTH'(2 * FULL_CIRCLE);

   // ------------------------------------------------------------------------
   // Stage handshake. Stage k loads when it is empty or stage k+1 loads.
   // ------------------------------------------------------------------------
   logic [LAST:0] stage_valid;
   logic [LAST:0] stage_ready;

   assign stage_ready[LAST] = !stage_valid[LAST] || !rsp_stall;

   for (genvar k = 0; k < LAST; k++) begin : g_ready
      assign stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
   end

   assign req_stall = !stage_ready[0];

   // ------------------------------------------------------------------------
   // Declination register.
   // ------------------------------------------------------------------------
   logic signed [DECL_WIDTH-1:0] decl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= '0;
      end else if (csr_write_enable) begin
         decl_ff <= csr_declination_arcmin;
      end
   end

   // ------------------------------------------------------------------------
   // Entry stage: fold the left half plane onto the right half by a turn of
   // 180 degrees, scale in the guard bits, and settle the axis cases exactly.
   // ------------------------------------------------------------------------
   chf_ctrl_type                  cctrl [0:N];
   logic signed [DW-1:0]          cx    [0:N];
   logic signed [DW-1:0]          cy    [0:N];
   logic signed [ANGLE_WIDTH-1:0] cz    [0:N];

   chf_ctrl_type                  entry_ctrl_ff, entry_ctrl_in;
   logic signed [DW-1:0]          entry_x_ff, entry_x_in;
   logic signed [DW-1:0]          entry_y_ff, entry_y_in;
   logic signed [ANGLE_WIDTH-1:0] entry_z_ff, entry_z_in;
   logic signed [DW-1:0]          x_ext, y_ext;
   logic                          x_neg, x_zero, y_zero;

   always_comb begin
      x_ext  = {{(DW - SAMPLE_WIDTH){req_mag_x[SAMPLE_WIDTH-1]}}, req_mag_x};
      y_ext  = {{(DW - SAMPLE_WIDTH){req_mag_y[SAMPLE_WIDTH-1]}}, req_mag_y};
      x_neg  = req_mag_x[SAMPLE_WIDTH-1];
      x_zero = (req_mag_x == '0);
      y_zero = (req_mag_y == '0);

      if (x_neg) begin
         entry_x_in = (-x_ext) <<< GUARD_BITS;
         entry_y_in = (-y_ext) <<< GUARD_BITS;
      end else begin
         entry_x_in = x_ext <<< GUARD_BITS;
         entry_y_in = y_ext <<< GUARD_BITS;
      end

      entry_ctrl_in.valid = req_valid;
      if (y_zero) begin
         // On the x axis, including the zero vector.
         entry_ctrl_in.hold = 1'b1;
         entry_z_in         = x_neg ? ANGLE_180 : '0;
      end else if (x_zero) begin
         // On the y axis.
         entry_ctrl_in.hold = 1'b1;
         entry_z_in         = req_mag_y[SAMPLE_WIDTH-1] ? -ANGLE_90 : ANGLE_90;
      end else begin
         entry_ctrl_in.hold = 1'b0;
         if (x_neg) begin
            entry_z_in = req_mag_y[SAMPLE_WIDTH-1] ? -ANGLE_180 : ANGLE_180;
         end else begin
            entry_z_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ctrl_ff <= '0;
      end else if (stage_ready[0]) begin
         entry_ctrl_ff <= entry_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         entry_x_ff <= entry_x_in;
         entry_y_ff <= entry_y_in;
         entry_z_ff <= entry_z_in;
      end
   end

   assign cctrl[0] = entry_ctrl_ff;
   assign cx[0]    = entry_x_ff;
   assign cy[0]    = entry_y_ff;
   assign cz[0]    = entry_z_ff;

   // ------------------------------------------------------------------------
   // CORDIC rotation stages, one shift amount each.
   // ------------------------------------------------------------------------
   for (genvar k = 1; k <= N; k++) begin : g_cordic
      chf_cordic_stage #(
         .DATA_WIDTH (DW),
         .SHIFT      (k - 1)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .load    (stage_ready[k]),
         .up_ctrl (cctrl[k-1]),
         .up_x    (cx[k-1]),
         .up_y    (cy[k-1]),
         .up_z    (cz[k-1]),
         .dn_ctrl (cctrl[k]),
         .dn_x    (cx[k]),
         .dn_y    (cy[k]),
         .dn_z    (cz[k])
      );
   end

   for (genvar k = 0; k <= N; k++) begin : g_cvalid
      assign stage_valid[k] = cctrl[k].valid;
   end

   // ------------------------------------------------------------------------
   // Post stage 1: round to 2^-7 degree (ties up), then form the fine
   // heading in 1/7680 degree with the declination added.
   // ------------------------------------------------------------------------
   logic                           p1_valid_ff;
   logic signed [FINE_WIDTH-1:0]   p1_fine_ff, p1_fine_in;
   logic signed [ANGLE_WIDTH:0]    round_sum;
   logic signed [QW-1:0]           angle_q7;
   logic signed [FINE_WIDTH-1:0]   q_ext, decl_ext;

   always_comb begin
      round_sum  = {cz[N][ANGLE_WIDTH-1], cz[N]} + (ANGLE_WIDTH + 1)'(ROUND_BIAS);
      angle_q7   = round_sum[ANGLE_WIDTH:ROUND_SHIFT];
      q_ext      = {{(FINE_WIDTH - QW){angle_q7[QW-1]}}, angle_q7};
      decl_ext   = {{(FINE_WIDTH - DECL_WIDTH){decl_ff[DECL_WIDTH-1]}}, decl_ff};
      // q * 60 as q * 64 - q * 4; arcminutes * 128.
      p1_fine_in = (q_ext <<< 6) - (q_ext <<< 2) + (decl_ext <<< 7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (stage_ready[N+1]) begin
         p1_valid_ff <= cctrl[N].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[N+1]) begin
         p1_fine_ff <= p1_fine_in;
      end
   end

   assign stage_valid[N+1] = p1_valid_ff;

   // ------------------------------------------------------------------------
   // Post stage 2: reduce to one full circle. The fine heading lies within
   // two circles on either side of zero, so one of four candidates is right.
   // The register keeps only the heading divided by 2^9.
   // ------------------------------------------------------------------------
   logic                          p2_valid_ff;
   logic        [QUOT_WIDTH-1:0]  p2_quot_ff, p2_quot_in;
   logic signed [FINE_WIDTH-1:0]  fine_plus, fine_plus2, fine_minus, fine_mod;

   always_comb begin
      fine_plus  = p1_fine_ff + FULL_FINE;
      fine_plus2 = p1_fine_ff + FULL_FINE2;
      fine_minus = p1_fine_ff - FULL_FINE;
      if (p1_fine_ff[FINE_WIDTH-1]) begin
         fine_mod = fine_plus[FINE_WIDTH-1] ? fine_plus2 : fine_plus;
      end else begin
         fine_mod = fine_minus[FINE_WIDTH-1] ? p1_fine_ff : fine_minus;
      end
      p2_quot_in = fine_mod[MOD_WIDTH-1:DEG_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (stage_ready[N+2]) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[N+2]) begin
         p2_quot_ff <= p2_quot_in;
      end
   end

   assign stage_valid[N+2] = p2_valid_ff;

   // ------------------------------------------------------------------------
   // Post stage 3: multiply by the reciprocal of 15.
   // ------------------------------------------------------------------------
   logic                  p3_valid_ff;
   logic [PROD_WIDTH-1:0] p3_prod_ff, p3_prod_in;

   assign p3_prod_in = PROD_WIDTH'(p2_quot_ff) * PROD_WIDTH'(DIV15_MULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (stage_ready[N+3]) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[N+3]) begin
         p3_prod_ff <= p3_prod_in;
      end
   end

   assign stage_valid[N+3] = p3_valid_ff;

   // ------------------------------------------------------------------------
   // Output register: whole degrees from the product.
   // ------------------------------------------------------------------------
   logic                     out_valid_ff;
   logic [HEADING_WIDTH-1:0] out_heading_ff, out_heading_in;

   assign out_heading_in = p3_prod_ff[DIV15_SHIFT + HEADING_WIDTH - 1:DIV15_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_ready[LAST]) begin
         out_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[LAST]) begin
         out_heading_ff <= out_heading_in;
      end
   end

   assign stage_valid[LAST]   = out_valid_ff;
   assign rsp_valid           = out_valid_ff;
   assign rsp_heading_degrees = out_heading_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // A delivered heading is always reduced to one circle.
   `CHF_ASSERT_IMPLY(a_heading_range, clock, reset, rsp_valid, rsp_heading_degrees < 9'd360)
   // The input stalls only when every stage holds a word.
   `CHF_ASSERT_IMPLY(a_stall_full, clock, reset, req_stall, (&stage_valid) && rsp_stall)
   // A free output side never holds back the input.
   `CHF_ASSERT_IMPLY(a_no_stall_free, clock, reset, !rsp_stall, !req_stall)
   // A result disappears only after it was taken.
   `CHF_ASSERT_IMPLY(a_no_drop, clock, reset, $fell(rsp_valid), $past(!rsp_stall) || $past(reset))

endmodule
